// ----- rtl/core/fbqm_pkg.sv -----
`default_nettype none

package fbqm_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int IDX_W      = 2;
    localparam int SIZE_W     = 28;
    localparam int DIM_W      = 16;

    // Request codes
    localparam logic [1:0] REQ_PRODUCE = 2'd0;
    localparam logic [1:0] REQ_ACQUIRE = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBUF = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    // Present modes
    localparam logic [1:0] MODE_IMMEDIATE = 2'd0;
    localparam logic [1:0] MODE_MAILBOX   = 2'd1;
    localparam logic [1:0] MODE_RELAXED   = 2'd2;
    localparam logic [1:0] MODE_FIFO      = 2'd3;

    // Configuration register indexes
    localparam logic CFG_QUEUE_MODE = 1'b0;
    localparam logic CFG_MAX_BYTES  = 1'b1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SIZE_W-1:0] data_size;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [IDX_W-1:0]  release_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] frame_index;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PRODUCE,
        OP_ACQUIRE,
        OP_RELEASE,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       status;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [IDX_W-1:0] rel;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/fbqm_front.sv -----
`default_nettype none

module fbqm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire fbqm_pkg::t_in_item i_item,
    input  wire logic [27:0]        i_max_bytes,
    output logic                    o_cmd_valid,
    output fbqm_pkg::t_cmd          o_cmd,
    input  wire logic               i_cmd_pop
);
    import fbqm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;
    logic       pop;

    // Classify: reject empty, oversize and unknown requests up front
    always_comb begin
        cls.op     = OP_REJECT;
        cls.status = ST_ERROR;
        cls.width  = i_item.frame_width;
        cls.height = i_item.frame_height;
        cls.rel    = i_item.release_index;
        case (i_item.req_type)
            REQ_PRODUCE: begin
                if (i_item.data_size == '0) begin
                    cls.status = ST_NOBUF;
                end else if (i_item.data_size > i_max_bytes) begin
                    cls.status = ST_ERROR;
                end else begin
                    cls.op     = OP_PRODUCE;
                    cls.status = ST_OK;
                end
            end
            REQ_ACQUIRE: begin
                cls.op     = OP_ACQUIRE;
                cls.status = ST_OK;
            end
            REQ_RELEASE: begin
                cls.op     = OP_RELEASE;
                cls.status = ST_OK;
            end
            default: begin
                cls.op     = OP_REJECT;
                cls.status = ST_ERROR;
            end
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_pop;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fbqm_back.sv -----
`default_nettype none

module fbqm_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_mode,
    input  wire logic            i_cmd_valid,
    input  wire fbqm_pkg::t_cmd  i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output fbqm_pkg::t_out_item  o_item
);
    import fbqm_pkg::*;

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);

    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [IW-1:0]   r_t, n_t;
    logic [IW-1:0]   r_free_ring [NUM_FRAMES];
    logic [IW-1:0]   r_free_head, n_free_head;
    logic [CW-1:0]   r_free_cnt, n_free_cnt;
    logic [IW-1:0]   r_fill_ring [NUM_FRAMES];
    logic [IW-1:0]   r_fill_head, n_fill_head;
    logic [CW-1:0]   r_fill_cnt, n_fill_cnt;
    logic [DIM_W-1:0] r_width  [NUM_FRAMES];
    logic [DIM_W-1:0] r_height [NUM_FRAMES];
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic            free_we;
    logic [IW-1:0]   free_wa, free_wd;
    logic            fill_we;
    logic [IW-1:0]   fill_wa, fill_wd;
    logic            rec_we;
    logic [IW-1:0]   rec_wa;
    logic [IW-1:0]   fill_ra;
    logic [IW-1:0]   fill_rd;
    logic [IW-1:0]   free_rd;
    logic            has_free, has_fill, free_full, fill_full, rel_bad;
    logic            take_free, reuse, overwrite;

    function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
        if (s >= (CW+1)'(NUM_FRAMES)) begin
            return IW'(s - (CW+1)'(NUM_FRAMES));
        end
        return IW'(s);
    endfunction

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] h);
        if (h == IW'(NUM_FRAMES - 1)) begin
            return '0;
        end
        return h + 1'b1;
    endfunction

    assign has_free  = (r_free_cnt != '0);
    assign has_fill  = (r_fill_cnt != '0);
    assign free_full = (r_free_cnt == CW'(NUM_FRAMES));
    assign fill_full = (r_fill_cnt == CW'(NUM_FRAMES));
    assign rel_bad   = ((CW+2)'(r_cmd.rel) >= (CW+2)'(NUM_FRAMES));

    // Pick the buffer source for a produce from the present mode
    always_comb begin
        take_free = 1'b0;
        reuse     = 1'b0;
        overwrite = 1'b0;
        case (i_mode)
            MODE_IMMEDIATE: begin
                reuse     = has_fill;
                take_free = !has_fill && has_free;
            end
            MODE_MAILBOX: begin
                take_free = has_free;
                reuse     = !has_free && has_fill;
            end
            MODE_RELAXED: begin
                take_free = has_free;
                overwrite = !has_free && has_fill;
            end
            default: begin
                take_free = has_free;
            end
        endcase
    end

    // Newest filled entry only for a relaxed overwrite; oldest otherwise
    assign fill_ra = (r_state == S_EXEC && r_cmd.op == OP_PRODUCE && overwrite)
                   ? wrap((CW+1)'(r_fill_head) + (CW+1)'(r_fill_cnt) - 1'b1)
                   : r_fill_head;
    assign fill_rd = r_fill_ring[fill_ra];
    assign free_rd = r_free_ring[r_free_head];

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_t         = r_t;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_fill_head = r_fill_head;
        n_fill_cnt  = r_fill_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        free_we     = 1'b0;
        free_wa     = wrap((CW+1)'(r_free_head) + (CW+1)'(r_free_cnt));
        free_wd     = fill_rd;
        fill_we     = 1'b0;
        fill_wa     = wrap((CW+1)'(r_fill_head) + (CW+1)'(r_fill_cnt));
        fill_wd     = free_rd;
        rec_we      = 1'b0;
        rec_wa      = free_rd;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_out   = '0;
                n_out_valid = 1'b1;
                case (r_cmd.op)
                    OP_ACQUIRE: begin
                        if (has_fill) begin
                            n_out.status      = ST_OK;
                            n_out.frame_index = IDX_W'(fill_rd);
                            n_out.out_width   = r_width[fill_rd];
                            n_out.out_height  = r_height[fill_rd];
                            n_fill_head       = inc(r_fill_head);
                            n_fill_cnt        = r_fill_cnt - 1'b1;
                        end else begin
                            n_out.status = ST_ERROR;
                        end
                    end
                    OP_RELEASE: begin
                        n_out.frame_index = r_cmd.rel;
                        if (rel_bad || free_full) begin
                            n_out.status = ST_DROP;
                        end else begin
                            n_out.status = ST_OK;
                            free_we      = 1'b1;
                            free_wd      = IW'(r_cmd.rel);
                            n_free_cnt   = r_free_cnt + 1'b1;
                        end
                    end
                    OP_PRODUCE: begin
                        if (take_free) begin
                            n_out.frame_index = IDX_W'(free_rd);
                            n_free_head       = inc(r_free_head);
                            n_free_cnt        = r_free_cnt - 1'b1;
                            rec_we            = 1'b1;
                            rec_wa            = free_rd;
                            if (!fill_full) begin
                                fill_we    = 1'b1;
                                fill_wd    = free_rd;
                                n_fill_cnt = r_fill_cnt + 1'b1;
                            end
                        end else if (overwrite) begin
                            n_out.frame_index = IDX_W'(fill_rd);
                            rec_we            = 1'b1;
                            rec_wa            = fill_rd;
                        end else if (reuse) begin
                            // Take the oldest, then drain the rest to free
                            n_t         = fill_rd;
                            rec_we      = 1'b1;
                            rec_wa      = fill_rd;
                            n_fill_head = inc(r_fill_head);
                            n_fill_cnt  = r_fill_cnt - 1'b1;
                            n_out_valid = r_out_valid && i_stall;
                            n_out       = r_out;
                            n_state     = S_DRAIN;
                        end else begin
                            n_out.status = ST_NOBUF;
                        end
                    end
                    default: begin
                        n_out.status = r_cmd.status;
                    end
                endcase
            end
            S_DRAIN: begin
                if (has_fill) begin
                    n_fill_head = inc(r_fill_head);
                    n_fill_cnt  = r_fill_cnt - 1'b1;
                    if (!free_full) begin
                        free_we    = 1'b1;
                        free_wd    = fill_rd;
                        n_free_cnt = r_free_cnt + 1'b1;
                    end
                end else begin
                    fill_we           = 1'b1;
                    fill_wa           = r_fill_head;
                    fill_wd           = r_t;
                    n_fill_cnt        = CW'(1);
                    n_out             = '0;
                    n_out.status      = ST_OK;
                    n_out.frame_index = IDX_W'(r_t);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_free_cnt  <= CW'(NUM_FRAMES);
            r_fill_head <= '0;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_free_ring[i] <= IW'(i);
            end
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_fill_head <= n_fill_head;
            r_fill_cnt  <= n_fill_cnt;
            r_out_valid <= n_out_valid;
            if (free_we) begin
                r_free_ring[free_wa] <= free_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_t   <= n_t;
        r_out <= n_out;
        if (fill_we) begin
            r_fill_ring[fill_wa] <= fill_wd;
        end
        if (rec_we) begin
            r_width[rec_wa]  <= r_cmd.width;
            r_height[rec_wa] <= r_cmd.height;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/frame_buffer_queue_manager.sv -----
`default_nettype none

// Channel   Direction  Handshake          Payload
// -------   ---------  -----------------  ---------------------------
// request   in         i_valid / o_stall  i_item  (fbqm_pkg::t_in_item)
// result    out        o_valid / i_stall  o_item  (fbqm_pkg::t_out_item)
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One result per item. The back end runs one item at a time: it pops the
// queue head, executes it into the result register, and the next item starts
// once the result is taken. An immediate or mailbox produce that recycles a
// frame first drains every other filled frame to the free ring and then
// requeues the recycled frame. The two-entry command queue keeps taking items,
// until it is full, while a result waits on i_stall. Reset is synchronous,
// active low: free ring holds 0..NUM_FRAMES-1, filled ring empty, mode strict
// FIFO, capacity zero.

module frame_buffer_queue_manager (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire fbqm_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output fbqm_pkg::t_out_item      o_item,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [27:0]         i_cfg_data
);
    import fbqm_pkg::*;

    logic [1:0]        r_queue_mode;
    logic [SIZE_W-1:0] r_max_bytes;
    logic              cmd_valid;
    logic              cmd_pop;
    t_cmd              cmd;

    // Configuration registers; the user must write them only while the block is idle (not enforced by the block)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_mode <= MODE_FIFO;
            r_max_bytes  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUEUE_MODE: r_queue_mode <= i_cfg_data[1:0];
                CFG_MAX_BYTES:  r_max_bytes  <= i_cfg_data;
                default:        r_max_bytes  <= r_max_bytes;
            endcase
        end
    end

    // Front: accept, classify, and queue the item
    fbqm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .i_max_bytes (r_max_bytes),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: advance the rings, record frame dimensions, and hold the result
    fbqm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_queue_mode),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire

// ----- tb/frame_buffer_queue_manager_tb.sv -----
`timescale 1ns / 1ps

module frame_buffer_queue_manager_tb;
    import fbqm_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Request code that the block must reject without touching its rings.
    localparam logic [1:0]        REQ_UNUSED = 2'd3;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = '1;
    localparam logic [DIM_W-1:0]  DIM_MAX    = '1;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    t_in_item           i_item      = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    t_out_item          o_item;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [SIZE_W-1:0]  i_cfg_data  = '0;

    frame_buffer_queue_manager i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Traffic shaping, set per test.
    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_off_cycles = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Predicted state of the queue manager.
    logic [1:0]        cur_mode;
    logic [SIZE_W-1:0] cur_max_bytes;
    logic [IDX_W-1:0]  free_ring   [NUM_FRAMES];
    int unsigned       free_head;
    int unsigned       free_count;
    logic [IDX_W-1:0]  filled_ring [NUM_FRAMES];
    int unsigned       filled_head;
    int unsigned       filled_count;
    logic [DIM_W-1:0]  frame_w     [NUM_FRAMES];
    logic [DIM_W-1:0]  frame_h     [NUM_FRAMES];

    t_out_item         pending_results[$];
    t_out_item         oldest_result;
    // Frames the consumer side currently holds; releases mostly hand these back.
    logic [IDX_W-1:0]  held_frames[$];

    function automatic void reset_queues();
        for (int i = 0; i < NUM_FRAMES; i++) begin
            free_ring[i]   = IDX_W'(i);
            filled_ring[i] = '0;
            frame_w[i]     = '0;
            frame_h[i]     = '0;
        end
        free_head     = 0;
        free_count    = NUM_FRAMES;
        filled_head   = 0;
        filled_count  = 0;
        cur_mode      = MODE_FIFO;
        cur_max_bytes = '0;
    endfunction

    // A push into a full ring is dropped silently.
    function automatic void push_free(logic [IDX_W-1:0] v);
        if (free_count < NUM_FRAMES) begin
            free_ring[(free_head + free_count) % NUM_FRAMES] = v;
            free_count++;
        end
    endfunction

    function automatic void push_filled(logic [IDX_W-1:0] v);
        if (filled_count < NUM_FRAMES) begin
            filled_ring[(filled_head + filled_count) % NUM_FRAMES] = v;
            filled_count++;
        end
    endfunction

    function automatic logic [IDX_W-1:0] pop_free();
        logic [IDX_W-1:0] v;
        v = free_ring[free_head];
        free_head = (free_head + 1) % NUM_FRAMES;
        free_count--;
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] pop_filled();
        logic [IDX_W-1:0] v;
        v = filled_ring[filled_head];
        filled_head = (filled_head + 1) % NUM_FRAMES;
        filled_count--;
        return v;
    endfunction

    function automatic void return_all_filled();
        while (filled_count > 0)
            push_free(pop_filled());
    endfunction

    // Advance the predicted queues by one request item and return its result.
    function automatic t_out_item serve_request(t_in_item rq);
        t_out_item        res;
        logic [IDX_W-1:0] buf_idx;
        bit               take;
        res        = '0;
        res.status = ST_ERROR;
        buf_idx    = '0;
        take       = 1'b0;
        case (rq.req_type)
            REQ_PRODUCE: begin
                if (rq.data_size == '0) begin
                    res.status = ST_NOBUF;
                end else if (rq.data_size > cur_max_bytes) begin
                    res.status = ST_ERROR;
                end else begin
                    res.status = ST_NOBUF;
                    case (cur_mode)
                        MODE_IMMEDIATE: begin
                            // Recycle the oldest filled frame, free the rest.
                            if (filled_count > 0) begin
                                buf_idx = pop_filled();
                                return_all_filled();
                                take = 1'b1;
                            end else if (free_count > 0) begin
                                buf_idx = pop_free();
                                take = 1'b1;
                            end
                        end
                        MODE_MAILBOX: begin
                            if (free_count > 0) begin
                                buf_idx = pop_free();
                                take = 1'b1;
                            end else if (filled_count > 0) begin
                                buf_idx = pop_filled();
                                return_all_filled();
                                take = 1'b1;
                            end
                        end
                        MODE_RELAXED: begin
                            if (free_count > 0) begin
                                buf_idx = pop_free();
                                take = 1'b1;
                            end else if (filled_count > 0) begin
                                // Overwrite the newest frame in place; rings stay.
                                buf_idx = filled_ring[(filled_head + filled_count - 1)
                                                      % NUM_FRAMES];
                                frame_w[buf_idx] = rq.frame_width;
                                frame_h[buf_idx] = rq.frame_height;
                                res.status      = ST_OK;
                                res.frame_index = buf_idx;
                            end
                        end
                        default: begin
                            if (free_count > 0) begin
                                buf_idx = pop_free();
                                take = 1'b1;
                            end
                        end
                    endcase
                    if (take) begin
                        frame_w[buf_idx] = rq.frame_width;
                        frame_h[buf_idx] = rq.frame_height;
                        push_filled(buf_idx);
                        res.status      = ST_OK;
                        res.frame_index = buf_idx;
                    end
                end
            end
            REQ_ACQUIRE: begin
                if (filled_count > 0) begin
                    buf_idx         = pop_filled();
                    res.status      = ST_OK;
                    res.frame_index = buf_idx;
                    res.out_width   = frame_w[buf_idx];
                    res.out_height  = frame_h[buf_idx];
                end
            end
            REQ_RELEASE: begin
                // Release always echoes the index, even when dropped.
                res.frame_index = rq.release_index;
                if (rq.release_index >= NUM_FRAMES || free_count >= NUM_FRAMES) begin
                    res.status = ST_DROP;
                end else begin
                    push_free(rq.release_index);
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_in_item frame_request(logic [1:0] req, logic [SIZE_W-1:0] size,
                                               logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                               logic [IDX_W-1:0] rel);
        t_in_item rq;
        rq.req_type      = req;
        rq.data_size     = size;
        rq.frame_width   = w;
        rq.frame_height  = h;
        rq.release_index = rel;
        return rq;
    endfunction

    // Mostly well-formed traffic (release what was acquired, acquire what is
    // filled, produce within capacity) with random content; the rest is noise.
    function automatic t_in_item make_request();
        t_in_item    rq;
        int unsigned pick;
        rq   = {$urandom(), $urandom()};
        pick = $urandom_range(99, 0);
        if (pick < 20) begin
            if ($urandom_range(3, 0) == 0)
                rq.data_size = '0;
            return rq;
        end
        if (held_frames.size() > 0 && pick < 45) begin
            rq.req_type      = REQ_RELEASE;
            rq.release_index = held_frames[$urandom_range(held_frames.size() - 1, 0)];
        end else if (filled_count > 0 && pick < 70) begin
            rq.req_type = REQ_ACQUIRE;
        end else begin
            rq.req_type = REQ_PRODUCE;
            if (cur_max_bytes == '0 || $urandom_range(9, 0) == 0)
                rq.data_size = SIZE_W'($urandom());
            else
                rq.data_size = SIZE_W'($urandom_range(cur_max_bytes, 1));
        end
        return rq;
    endfunction

    // Offer one item, hold it until accepted, then predict its result.
    task automatic send_request(input t_in_item rq);
        t_out_item res;
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= rq;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        res = serve_request(rq);
        pending_results.push_back(res);
        if (rq.req_type == REQ_ACQUIRE && res.status == ST_OK)
            held_frames.push_back(res.frame_index);
        if (rq.req_type == REQ_RELEASE && res.status == ST_OK) begin
            for (int k = 0; k < held_frames.size(); k++) begin
                if (held_frames[k] == rq.release_index) begin
                    held_frames.delete(k);
                    break;
                end
            end
        end
    endtask

    // Drop valid, let every expected result come out, then let the back end settle.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_index, input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (reg_index == CFG_QUEUE_MODE)
            cur_mode = value[1:0];
        else
            cur_max_bytes = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Upper bits of the mode write carry junk; only the low two bits count.
    task automatic configure(input logic [1:0] mode, input logic [SIZE_W-1:0] max_bytes);
        logic [SIZE_W-1:0] mode_word;
        wait_idle();
        mode_word      = SIZE_W'($urandom());
        mode_word[1:0] = mode;
        write_reg(CFG_QUEUE_MODE, mode_word);
        write_reg(CFG_MAX_BYTES, max_bytes);
    endtask

    task automatic test_reset_state();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_request(frame_request(REQ_PRODUCE, '0, DIM_MAX, DIM_MAX, 2'd0));
        send_request(frame_request(REQ_PRODUCE, 28'd1, 16'd1, 16'd1, 2'd0));
        send_request(frame_request(REQ_ACQUIRE, SIZE_MAX, DIM_MAX, DIM_MAX, 2'd1));
        send_request(frame_request(REQ_RELEASE, '0, '0, '0, 2'd3));
        send_request(frame_request(REQ_UNUSED, SIZE_MAX, DIM_MAX, DIM_MAX, 2'd3));
        wait_idle();
    endtask

    task automatic test_fifo_mode();
        configure(MODE_FIFO, SIZE_MAX);
        send_request(frame_request(REQ_PRODUCE, SIZE_MAX, '0, '0, 2'd0));
        send_request(frame_request(REQ_PRODUCE, 28'd1, DIM_MAX, DIM_MAX, 2'd3));
        send_request(frame_request(REQ_PRODUCE, 28'h5555555, 16'haaaa, 16'h5555, 2'd1));
        send_request(frame_request(REQ_PRODUCE, 28'haaaaaaa, 16'h5555, 16'haaaa, 2'd2));
        // Every buffer is filled now; strict FIFO has nothing to give.
        send_request(frame_request(REQ_PRODUCE, 28'd7, 16'd3, 16'd4, 2'd0));
        send_request(frame_request(REQ_ACQUIRE, '0, '0, '0, 2'd0));
        send_request(frame_request(REQ_ACQUIRE, '0, '0, '0, 2'd0));
        send_request(frame_request(REQ_RELEASE, '0, '0, '0, 2'd0));
        send_request(frame_request(REQ_RELEASE, '0, '0, '0, 2'd1));
        wait_idle();
    endtask

    task automatic test_present_modes();
        configure(MODE_MAILBOX, 28'd4096);
        send_request(frame_request(REQ_PRODUCE, 28'd4097, 16'd9, 16'd9, 2'd0));
        send_request(frame_request(REQ_PRODUCE, 28'd4096, 16'd640, 16'd480, 2'd0));
        send_request(frame_request(REQ_PRODUCE, 28'd100, 16'd800, 16'd600, 2'd0));
        // No free buffer left: mailbox recycles the oldest filled frame.
        send_request(frame_request(REQ_PRODUCE, 28'd200, 16'd1024, 16'd768, 2'd0));

        configure(MODE_IMMEDIATE, 28'd4096);
        send_request(frame_request(REQ_PRODUCE, 28'd1, 16'd1920, 16'd1080, 2'd0));
        send_request(frame_request(REQ_ACQUIRE, '0, '0, '0, 2'd0));
        send_request(frame_request(REQ_PRODUCE, 28'd2, 16'd1280, 16'd720, 2'd0));

        configure(MODE_RELAXED, SIZE_MAX);
        repeat (4)
            send_request(frame_request(REQ_PRODUCE, 28'd5, 16'($urandom()),
                                       16'($urandom()), 2'd0));
        send_request(frame_request(REQ_ACQUIRE, '0, '0, '0, 2'd0));
        wait_idle();
    endtask

    // Hold the result side off while items keep coming, so the block fills up.
    task automatic test_backpressure();
        configure(MODE_IMMEDIATE, SIZE_MAX);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge i_clk);
        hold_off_cycles = 80;
        repeat (30) send_request(make_request());
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [1:0] mode,
                                       input logic [SIZE_W-1:0] max_bytes,
                                       input int idle_pct, input int stall_rate,
                                       input int num_items);
        configure(mode, max_bytes);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        repeat (num_items) send_request(make_request());
        wait_idle();
    endtask

    // Result side: random stall, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    function automatic void check_field(string field_name, logic [DIM_W-1:0] want,
                                        logic [DIM_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field_name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_item);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status", DIM_W'(oldest_result.status), DIM_W'(o_item.status));
                check_field("frame_index", DIM_W'(oldest_result.frame_index),
                            DIM_W'(o_item.frame_index));
                check_field("out_width", oldest_result.out_width, o_item.out_width);
                check_field("out_height", oldest_result.out_height, o_item.out_height);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        reset_queues();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_fifo_mode();
        test_present_modes();
        test_backpressure();

        test_random_traffic(MODE_FIFO,      SIZE_MAX,  0,  0,  140);
        test_random_traffic(MODE_MAILBOX,   28'd4096,  72, 0,  140);
        test_random_traffic(MODE_IMMEDIATE, SIZE_MAX,  0,  72, 140);
        test_random_traffic(MODE_RELAXED,   28'd1,     32, 32, 140);
        test_random_traffic(MODE_MAILBOX,   '0,        32, 32, 30);
        test_random_traffic(MODE_IMMEDIATE, SIZE_W'($urandom_range(65535, 2)), 32, 32, 120);
        test_random_traffic(MODE_RELAXED,   SIZE_MAX,  0,  0,  100);

        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
